>>> sv/pn3d_pkg.sv
// ----------------------------------------------------------------------------
// pn3d_pkg
// Shared widths, constants and register indexes of the octave noise core.
// ----------------------------------------------------------------------------
`default_nettype none
package pn3d_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = 8;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = 3;
  localparam int COORD_W     = 24;
  localparam int OUT_W       = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_GAIN = 2'd2;

  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage
`default_nettype wire

>>> sv/pn3d_mul.sv
// ----------------------------------------------------------------------------
// pn3d_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module pn3d_mul (
  input  wire                                     clk,
  input  wire signed [pn3d_pkg::MUL_A_W-1:0]      mul_a,
  input  wire signed [pn3d_pkg::MUL_B_W-1:0]      mul_b,
  output logic signed [pn3d_pkg::MUL_P_W-1:0]     prod_r
);

  logic signed [pn3d_pkg::MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = pn3d_pkg::MUL_P_W'(mul_a) * pn3d_pkg::MUL_P_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

>>> sv/perlin_noise_3d_octaves_core.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves_core
// Octave-summed 3D improved gradient noise over a loadable permutation table.
// ----------------------------------------------------------------------------
// Evaluation: an evaluate word is worked one octave after another, then
//   normalised; a load word writes the table in the cycle it is accepted.
// Throughput: one point at a time, each octave stepped in sequence, set by the single
//   read port of the permutation table and the one shared multiplier.
// Reset: sequencer, output valid and registers return to their defaults;
//   the permutation table holds no defined value until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module perlin_noise_3d_octaves_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_kind,
  input  wire [pn3d_pkg::COORD_W-1:0]         in_coord_x,
  input  wire [pn3d_pkg::COORD_W-1:0]         in_coord_y,
  input  wire [pn3d_pkg::COORD_W-1:0]         in_coord_z,
  input  wire [pn3d_pkg::IDX_W-1:0]           in_entry_index,
  input  wire [pn3d_pkg::IDX_W-1:0]           in_entry_value,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [pn3d_pkg::OUT_W-1:0]          out_noise_value,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [pn3d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [pn3d_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [4:0] S_RD_CX0   = 5'd0;
  localparam logic [4:0] S_RD_CX1   = 5'd1;
  localparam logic [4:0] S_RD_A0    = 5'd2;
  localparam logic [4:0] S_RD_A1    = 5'd3;
  localparam logic [4:0] S_RD_B0    = 5'd4;
  localparam logic [4:0] S_RD_B1    = 5'd5;
  localparam logic [4:0] S_RD_AA0   = 5'd6;
  localparam logic [4:0] S_RD_AA1   = 5'd7;
  localparam logic [4:0] S_RD_AB0   = 5'd8;
  localparam logic [4:0] S_RD_AB1   = 5'd9;
  localparam logic [4:0] S_RD_BA0   = 5'd10;
  localparam logic [4:0] S_RD_BA1   = 5'd11;
  localparam logic [4:0] S_RD_BB0   = 5'd12;
  localparam logic [4:0] S_RD_BB1   = 5'd13;
  localparam logic [4:0] S_HASH_END = 5'd14;
  localparam logic [4:0] S_LX0      = 5'd15;
  localparam logic [4:0] S_LX1      = 5'd16;
  localparam logic [4:0] S_LX2      = 5'd17;
  localparam logic [4:0] S_LX3      = 5'd18;
  localparam logic [4:0] S_LY0      = 5'd19;
  localparam logic [4:0] S_LY1      = 5'd20;
  localparam logic [4:0] S_LY_END   = 5'd21;
  localparam logic [4:0] S_LZ       = 5'd22;
  localparam logic [4:0] S_NOISE    = 5'd23;
  localparam logic [4:0] S_ACC      = 5'd24;
  localparam logic [4:0] S_AMP      = 5'd25;
  localparam logic [4:0] S_NORM_LO  = 5'd26;
  localparam logic [4:0] S_NORM_HI  = 5'd27;
  localparam logic [4:0] S_FINISH   = 5'd28;
  localparam logic [4:0] S_EMIT     = 5'd29;

  localparam logic [4:0] FADE_STEPS = 5'd12;

  localparam int FB = pn3d_pkg::FRAC_BITS;
  localparam int IW = pn3d_pkg::IDX_W;
  localparam int CW = pn3d_pkg::COORD_W;
  localparam int AW = pn3d_pkg::MUL_A_W;
  localparam int BW = pn3d_pkg::MUL_B_W;
  localparam int PW = pn3d_pkg::MUL_P_W;
  localparam int NW = PW + 20;

  localparam logic signed [BW-1:0] ONE_Q     = BW'(65536);
  localparam logic signed [BW-1:0] TEN_Q     = BW'(655360);
  localparam logic signed [BW-1:0] FIFTEEN_Q = BW'(983040);
  localparam logic [FB:0]          FADE_ONE  = 17'd65536;
  localparam logic signed [NW-1:0] ROUND_Q   = NW'(64'd2147483648);

  function automatic logic signed [19:0] grad_q(input logic [3:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y,
                                                input logic signed [17:0] z);
    logic signed [19:0] xe;
    logic signed [19:0] ye;
    logic signed [19:0] ze;
    logic signed [19:0] u;
    logic signed [19:0] v;
    xe = {{2{x[17]}}, x};
    ye = {{2{y[17]}}, y};
    ze = {{2{z[17]}}, z};
    u = (h < 4'd8) ? xe : ye;
    if (h < 4'd4) begin
      v = ye;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = xe;
    end else begin
      v = ze;
    end
    grad_q = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic                         state_r;
  logic [4:0]                   step_r;
  logic                         out_valid_r;
  logic [pn3d_pkg::OUT_W-1:0]   out_noise_r;
  logic [3:0]                   oct_count_r;
  logic [15:0]                  persistence_r;
  logic [16:0]                  gain_r;

  logic [CW-1:0]                px_r, py_r, pz_r;
  logic [pn3d_pkg::OCT_W-1:0]   oct_r, last_r, last_nxt;
  logic [FB:0]                  amp_r;
  logic signed [PW-1:0]         total_r;
  logic signed [NW-1:0]         norm_r;
  logic [pn3d_pkg::OUT_W-1:0]   res_r;
  logic [FB:0]                  fu_r, fv_r, fw_r;
  logic [IW-1:0]                a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic [3:0]                   h_r [8];
  logic signed [20:0]           lx_r [4];
  logic signed [20:0]           ly_r [2];

  logic [IW-1:0]                perm_mem [pn3d_pkg::TABLE_SIZE];
  logic [IW-1:0]                rd_addr, rd_q;

  logic                         in_acc, load_we, out_free;
  logic [IW-1:0]                cx, cy, cz;
  logic [FB-1:0]                fade_t;
  logic signed [BW-1:0]         fade_first, pq;
  logic [FB:0]                  fade_cl;
  logic signed [17:0]           fx0, fy0, fz0, fx1, fy1, fz1;
  logic signed [19:0]           g [8];
  logic signed [BW-1:0]         lerp_sum, noise_r, noise_q;
  logic signed [AW-1:0]         mul_a;
  logic signed [BW-1:0]         mul_b;
  logic signed [PW-1:0]         mul_p;
  logic signed [NW-1:0]         fin_sum;
  logic signed [27:0]           fin_q;
  logic [pn3d_pkg::OUT_W-1:0]   fin_cl;

  assign in_acc   = in_valid && !in_stall;
  assign load_we  = in_acc && !in_kind;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_noise_value = out_noise_r;

  assign cx = px_r[CW-1:FB];
  assign cy = py_r[CW-1:FB];
  assign cz = pz_r[CW-1:FB];
  assign fx0 = $signed({2'b00, px_r[FB-1:0]});
  assign fy0 = $signed({2'b00, py_r[FB-1:0]});
  assign fz0 = $signed({2'b00, pz_r[FB-1:0]});
  assign fx1 = fx0 - 18'sd65536;
  assign fy1 = fy0 - 18'sd65536;
  assign fz1 = fz0 - 18'sd65536;

  always_comb begin
    priority if (oct_count_r == 4'd0) begin
      last_nxt = '0;
    end else if (oct_count_r > 4'(pn3d_pkg::MAX_OCTAVES)) begin
      last_nxt = pn3d_pkg::OCT_W'(pn3d_pkg::MAX_OCTAVES - 1);
    end else begin
      last_nxt = pn3d_pkg::OCT_W'(oct_count_r - 4'd1);
    end
  end

  // permutation table: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (load_we) begin
      perm_mem[in_entry_index] <= in_entry_value;
    end
    rd_q <= perm_mem[rd_addr];
  end

  always_comb begin
    unique case (step_r)
      S_RD_CX0: rd_addr = cx;
      S_RD_CX1: rd_addr = cx + IW'(1);
      S_RD_A0:  rd_addr = a_r;
      S_RD_A1:  rd_addr = a_r + IW'(1);
      S_RD_B0:  rd_addr = b_r;
      S_RD_B1:  rd_addr = b_r + IW'(1);
      S_RD_AA0: rd_addr = aa_r;
      S_RD_AA1: rd_addr = aa_r + IW'(1);
      S_RD_AB0: rd_addr = ab_r;
      S_RD_AB1: rd_addr = ab_r + IW'(1);
      S_RD_BA0: rd_addr = ba_r;
      S_RD_BA1: rd_addr = ba_r + IW'(1);
      S_RD_BB0: rd_addr = bb_r;
      S_RD_BB1: rd_addr = bb_r + IW'(1);
      default:  rd_addr = cx;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      g[i] = grad_q(h_r[i], i[0] ? fx1 : fx0, i[1] ? fy1 : fy0, i[2] ? fz1 : fz0);
    end
  end

  assign pq = mul_p[FB+BW-1:FB];

  always_comb begin
    unique case (step_r[3:2])
      2'd0:    fade_t = px_r[FB-1:0];
      2'd1:    fade_t = py_r[FB-1:0];
      default: fade_t = pz_r[FB-1:0];
    endcase
  end

  assign fade_first = $signed({4'b0000, fade_t, 2'b00}) + $signed({5'b00000, fade_t, 1'b0})
                      - FIFTEEN_Q;

  always_comb begin
    priority if (pq[BW-1]) begin
      fade_cl = '0;
    end else if (pq > $signed({{(BW-FB-1){1'b0}}, FADE_ONE})) begin
      fade_cl = FADE_ONE;
    end else begin
      fade_cl = pq[FB:0];
    end
  end

  assign noise_r = BW'(ly_r[0]) + pq;
  assign noise_q = (noise_r + ONE_Q) >>> 1;

  always_comb begin
    unique case (step_r)
      S_LX0:   lerp_sum = '0;
      S_LX1:   lerp_sum = BW'(g[0]) + pq;
      S_LX2:   lerp_sum = BW'(g[2]) + pq;
      S_LX3:   lerp_sum = BW'(g[4]) + pq;
      S_LY0:   lerp_sum = BW'(g[6]) + pq;
      S_LY1:   lerp_sum = BW'(lx_r[0]) + pq;
      S_LY_END: lerp_sum = BW'(lx_r[2]) + pq;
      default: lerp_sum = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (step_r < FADE_STEPS) begin
      mul_a = $signed({2'b00, fade_t});
      unique case (step_r[1:0])
        2'd0:    mul_b = fade_first;
        2'd1:    mul_b = pq + TEN_Q;
        default: mul_b = pq;
      endcase
    end else begin
      unique case (step_r)
        S_LX0: begin
          mul_a = $signed({1'b0, fu_r});
          mul_b = BW'(g[1]) - BW'(g[0]);
        end
        S_LX1: begin
          mul_a = $signed({1'b0, fu_r});
          mul_b = BW'(g[3]) - BW'(g[2]);
        end
        S_LX2: begin
          mul_a = $signed({1'b0, fu_r});
          mul_b = BW'(g[5]) - BW'(g[4]);
        end
        S_LX3: begin
          mul_a = $signed({1'b0, fu_r});
          mul_b = BW'(g[7]) - BW'(g[6]);
        end
        S_LY0: begin
          mul_a = $signed({1'b0, fv_r});
          mul_b = BW'(lx_r[1]) - BW'(lx_r[0]);
        end
        S_LY1: begin
          mul_a = $signed({1'b0, fv_r});
          mul_b = BW'(lx_r[3]) - BW'(lx_r[2]);
        end
        S_LZ: begin
          mul_a = $signed({1'b0, fw_r});
          mul_b = BW'(ly_r[1]) - BW'(ly_r[0]);
        end
        S_NOISE: begin
          mul_a = $signed({1'b0, amp_r});
          mul_b = noise_q;
        end
        S_ACC: begin
          mul_a = $signed({1'b0, amp_r});
          mul_b = $signed({6'b000000, persistence_r});
        end
        S_NORM_LO: begin
          mul_a = $signed({1'b0, gain_r});
          mul_b = $signed({2'b00, total_r[19:0]});
        end
        S_NORM_HI: begin
          mul_a = $signed({1'b0, gain_r});
          mul_b = $signed({{2{total_r[PW-1]}}, total_r[PW-1:20]});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  pn3d_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (mul_p)
  );

  assign fin_sum = norm_r + $signed({mul_p, 20'b0}) + ROUND_Q;
  assign fin_q   = fin_sum[NW-1:32];

  always_comb begin
    priority if (fin_q[27]) begin
      fin_cl = '0;
    end else if (|fin_q[26:16]) begin
      fin_cl = '1;
    end else begin
      fin_cl = fin_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= S_RD_CX0;
      out_valid_r   <= 1'b0;
      oct_count_r   <= 4'd1;
      persistence_r <= 16'd32768;
      gain_r        <= 17'd65536;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pn3d_pkg::CFG_OCTAVE_COUNT:   oct_count_r   <= cfg_data[3:0];
          pn3d_pkg::CFG_PERSISTENCE:    persistence_r <= cfg_data[15:0];
          pn3d_pkg::CFG_NORMALIZE_GAIN: gain_r        <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_RUN && step_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_kind) begin
            state_r <= ST_RUN;
            step_r  <= S_RD_CX0;
          end
        end
        ST_RUN: begin
          priority if (step_r == S_AMP) begin
            step_r <= (oct_r == last_r) ? S_NORM_LO : S_RD_CX0;
          end else if (step_r == S_EMIT) begin
            if (out_free) begin
              state_r     <= ST_IDLE;
            end
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_kind) begin
      px_r    <= in_coord_x;
      py_r    <= in_coord_y;
      pz_r    <= in_coord_z;
      oct_r   <= '0;
      last_r  <= last_nxt;
      amp_r   <= FADE_ONE;
      total_r <= '0;
    end else if (state_r == ST_RUN) begin
      unique case (step_r)
        S_RD_CX1:   a_r <= rd_q + cy;
        S_RD_A0:    b_r <= rd_q + cy;
        S_RD_A1:    aa_r <= rd_q + cz;
        S_RD_B0: begin
          ab_r <= rd_q + cz;
          fu_r <= fade_cl;
        end
        S_RD_B1:    ba_r <= rd_q + cz;
        S_RD_AA0:   bb_r <= rd_q + cz;
        S_RD_AA1:   h_r[0] <= rd_q[3:0];
        S_RD_AB0: begin
          h_r[4] <= rd_q[3:0];
          fv_r   <= fade_cl;
        end
        S_RD_AB1:   h_r[2] <= rd_q[3:0];
        S_RD_BA0:   h_r[6] <= rd_q[3:0];
        S_RD_BA1:   h_r[1] <= rd_q[3:0];
        S_RD_BB0: begin
          h_r[5] <= rd_q[3:0];
          fw_r   <= fade_cl;
        end
        S_RD_BB1:   h_r[3] <= rd_q[3:0];
        S_HASH_END: h_r[7] <= rd_q[3:0];
        S_LX1:      lx_r[0] <= lerp_sum[20:0];
        S_LX2:      lx_r[1] <= lerp_sum[20:0];
        S_LX3:      lx_r[2] <= lerp_sum[20:0];
        S_LY0:      lx_r[3] <= lerp_sum[20:0];
        S_LY1:      ly_r[0] <= lerp_sum[20:0];
        S_LY_END:   ly_r[1] <= lerp_sum[20:0];
        S_ACC:      total_r <= total_r + mul_p;
        S_AMP: begin
          amp_r <= mul_p[FB+FB:FB];
          oct_r <= oct_r + pn3d_pkg::OCT_W'(1);
          px_r  <= {px_r[CW-2:0], 1'b0};
          py_r  <= {py_r[CW-2:0], 1'b0};
          pz_r  <= {pz_r[CW-2:0], 1'b0};
        end
        S_NORM_HI:  norm_r <= {{20{mul_p[PW-1]}}, mul_p};
        S_FINISH:   res_r <= fin_cl;
        S_EMIT: begin
          if (out_free) begin
            out_noise_r <= res_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/pn3d_chk.sv
// ----------------------------------------------------------------------------
// pn3d_chk
// Port-level checks of the octave noise core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pn3d_chk (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             in_kind,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire [pn3d_pkg::OUT_W-1:0]       out_noise_value
);

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_noise_value)))
    else $error("stalled result word changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind) |=> in_stall)
    else $error("evaluate word did not block the input");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_kind) |=> !in_stall)
    else $error("load word blocked the input");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without an evaluation in flight");

endmodule

bind perlin_noise_3d_octaves_core pn3d_chk u_pn3d_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_noise_value (out_noise_value)
);
`default_nettype wire

>>> bench/pn3d_tb_pkg.sv
// ----------------------------------------------------------------------------
// pn3d_tb_pkg
// Word kinds shared by the noise core bench and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pn3d_tb_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

endpackage

>>> bench/perlin_noise_3d_octaves_checker.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves_checker
// Watches the input, result and register channels of the octave noise core.
// Keeps its own permutation table and register copies, predicts the noise
// value of every accepted evaluate word and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module perlin_noise_3d_octaves_checker
  import pn3d_pkg::*;
  import pn3d_tb_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_stall,
  input  wire                   in_kind,
  input  wire [COORD_W-1:0]     in_coord_x,
  input  wire [COORD_W-1:0]     in_coord_y,
  input  wire [COORD_W-1:0]     in_coord_z,
  input  wire [IDX_W-1:0]       in_entry_index,
  input  wire [IDX_W-1:0]       in_entry_value,
  input  wire                   out_valid,
  input  wire                   out_stall,
  input  wire [OUT_W-1:0]       out_noise_value,
  input  wire                   cfg_valid,
  input  wire                   cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;

  logic [7:0]       perm_tab [TABLE_SIZE];
  logic [3:0]       octave_count;
  logic [15:0]      persistence;
  logic [16:0]      normalize_gain;
  logic [OUT_W-1:0] noise_q [$];
  int               err_cnt;

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint fade(longint t);
    longint f;
    f = mulq(t, t * 6 - 15 * ONE_Q) + 10 * ONE_Q;
    f = mulq(t, f);
    f = mulq(t, f);
    f = mulq(t, f);
    if (f < 0) f = 0;
    if (f > ONE_Q) f = ONE_Q;
    return f;
  endfunction

  function automatic longint lerp(longint t, longint a, longint b);
    return a + mulq(t, b - a);
  endfunction

  function automatic longint grad(longint hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint pick(longint i);
    return longint'(perm_tab[i[7:0]]);
  endfunction

  function automatic longint octave_noise(longint cx, longint cy, longint cz,
                                          longint x, longint y, longint z);
    longint u, v, w, a, aa, ab, b, ba, bb, x1, y1, z1, r;
    u = fade(x); v = fade(y); w = fade(z);
    a = pick(cx) + cy;
    aa = pick(a) + cz;
    ab = pick(a + 1) + cz;
    b = pick(cx + 1) + cy;
    ba = pick(b) + cz;
    bb = pick(b + 1) + cz;
    x1 = x - ONE_Q; y1 = y - ONE_Q; z1 = z - ONE_Q;
    r = lerp(w,
      lerp(v,
        lerp(u, grad(pick(aa), x, y, z), grad(pick(ba), x1, y, z)),
        lerp(u, grad(pick(ab), x, y1, z), grad(pick(bb), x1, y1, z))),
      lerp(v,
        lerp(u, grad(pick(aa + 1), x, y, z1), grad(pick(ba + 1), x1, y, z1)),
        lerp(u, grad(pick(ab + 1), x, y1, z1), grad(pick(bb + 1), x1, y1, z1))));
    return (r + ONE_Q) >>> 1;
  endfunction

  function automatic logic [OUT_W-1:0] fractal_noise(longint cx, longint cy, longint cz);
    longint n, amp, total, px, py, pz, res;
    n = octave_count;
    amp = 65536;
    total = 0;
    if (n < 1) n = 1;
    if (n > MAX_OCTAVES) n = MAX_OCTAVES;
    for (int i = 0; i < n; i++) begin
      px = cx << i; py = cy << i; pz = cz << i;
      total += octave_noise((px >> FRAC_BITS) & 255, (py >> FRAC_BITS) & 255,
                            (pz >> FRAC_BITS) & 255, px & 16'hFFFF, py & 16'hFFFF,
                            pz & 16'hFFFF) * amp;
      amp = (amp * longint'(persistence)) >> 16;
    end
    res = (total * longint'(normalize_gain) + (64'sd1 <<< (FRAC_BITS + 15)))
          >>> (FRAC_BITS + 16);
    if (res < 0) res = 0;
    if (res > 65535) res = 65535;
    return res[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      octave_count = 4'd1;
      persistence = 16'd32768;
      normalize_gain = 17'd65536;
      noise_q.delete();
      err_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (noise_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, expected none, actual %0d",
                   $time, out_noise_value);
        end else begin
          want = noise_q.pop_front();
          if (want !== out_noise_value) begin
            err_cnt++;
            $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                     $time, want, out_noise_value);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OCTAVE_COUNT:   octave_count = cfg_data[3:0];
          CFG_PERSISTENCE:    persistence = cfg_data[15:0];
          CFG_NORMALIZE_GAIN: normalize_gain = cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_LOAD)
          perm_tab[in_entry_index] = in_entry_value;
        else
          noise_q.push_back(fractal_noise(in_coord_x, in_coord_y, in_coord_z));
      end
    end
    mismatches <= err_cnt;
    outstanding <= noise_q.size();
  end

endmodule

>>> bench/perlin_noise_3d_octaves_core_tb.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves_core_tb
// Loads a shuffled permutation table, evaluates directed corner points, then
// runs random load and evaluate words over several register settings with
// random gaps and result stalls, including one long hold-off of results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module perlin_noise_3d_octaves_core_tb;
  import pn3d_pkg::*;
  import pn3d_tb_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 26 * MAX_OCTAVES + 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  wire                   in_stall;
  logic                  in_kind = KIND_LOAD;
  logic [COORD_W-1:0]    in_coord_x = '0;
  logic [COORD_W-1:0]    in_coord_y = '0;
  logic [COORD_W-1:0]    in_coord_z = '0;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic [IDX_W-1:0]      in_entry_value = '0;
  wire                   out_valid;
  logic                  out_stall = 1'b0;
  wire [OUT_W-1:0]       out_noise_value;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;
  int                    cycles = 0;
  bit                    squeeze_req = 1'b0;

  perlin_noise_3d_octaves_core dut (.*);

  perlin_noise_3d_octaves_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int r;
      r = $urandom_range(0, 99);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        repeat (900) @(posedge clk);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z, logic [IDX_W-1:0] idx,
                           logic [IDX_W-1:0] val);
    int r;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_entry_index <= idx;
    in_entry_value <= val;
    do @(posedge clk); while (in_stall);
    r = $urandom_range(0, 99);
    if (r >= 65) begin
      in_valid <= 1'b0;
      if (r < 95) repeat ($urandom_range(1, 4)) @(posedge clk);
      else repeat ($urandom_range(10, 40)) @(posedge clk);
    end
  endtask

  task automatic eval_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z);
    send_word(KIND_EVAL, x, y, z, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom_range(0, 3)) << FRAC_BITS | COORD_W'($urandom_range(0, 65535));
      1: return {8'hFF, 16'($urandom)};
      2: return {8'($urandom), 16'hFFFF};
      3: return {8'($urandom), 16'h0000};
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] shuffle [TABLE_SIZE];
    logic [7:0] tmp;
    int j;
    int phase_oct  [7] = '{8, 0, 15, 3, 2, 5, 1};
    int phase_pers [7] = '{65535, 0, 32768, 40000, 65535, 20000, 1};
    int phase_gain [7] = '{131071, 0, 65536, 30000, 65536, 90000, 70000};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < TABLE_SIZE; i++) shuffle[i] = i[7:0];
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = tmp;
    end
    for (int i = 0; i < TABLE_SIZE; i++)
      send_word(KIND_LOAD, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                i[7:0], shuffle[i]);

    eval_point('0, '0, '0);
    eval_point('1, '1, '1);
    eval_point(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
    eval_point(24'hFF0000, 24'hFF0000, 24'hFF0000);
    eval_point(24'h008000, 24'h000001, 24'hFFFFFE);
    eval_point(24'h7F8000, 24'h80C000, 24'h014000);
    eval_point(24'hFFFFFF, '0, 24'h00FFFF);
    send_word(KIND_LOAD, '0, '0, '0, 8'hFF, 8'hFF);
    send_word(KIND_LOAD, '0, '0, '0, 8'h00, 8'h00);
    eval_point(24'hFF8000, 24'h00FFFF, 24'hFF0001);

    for (int p = 0; p < 7; p++) begin
      settle();
      write_reg(CFG_OCTAVE_COUNT, CFG_DATA_W'(phase_oct[p]));
      write_reg(CFG_PERSISTENCE, CFG_DATA_W'(phase_pers[p]));
      write_reg(CFG_NORMALIZE_GAIN, CFG_DATA_W'(phase_gain[p]));
      if (p == 1) squeeze_req = 1'b1;
      for (int k = 0; k < 220; k++) begin
        if ($urandom_range(0, 99) < 20)
          send_word(KIND_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                    COORD_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        else
          eval_point(rand_coord(), rand_coord(), rand_coord());
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
